[rtl/core/assert_macros.svh]
// assertion macros shared by the rtl that checks itself
// needs a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/slr_pkg.sv]
// types, constants and palette lookup for the screen line renderer
// no dependencies
package slr_pkg;

    localparam int ScreenBytes   = 6912;
    localparam int BitmapBytes   = 6144;
    localparam int AttrBytes     = ScreenBytes - BitmapBytes;
    localparam int BitmapAw      = 13;
    localparam int AttrAw        = 10;
    localparam int TopBorderRows = 4;
    localparam int DisplayRows   = 120;
    localparam int BottomStart   = TopBorderRows + DisplayRows;

    // floor(x/5) == (x*205) >> 10 for x < 1024; with x = 8*rel this is (rel*205) >> 7
    localparam logic [7:0] RecipFive = 8'd205;

    localparam logic WriteKind  = 1'b0;
    localparam logic RenderKind = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [12:0] address;
        logic [7:0]  data;
        logic [6:0]  line;
        logic [4:0]  group;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] pixel_a;
        logic [15:0] pixel_b;
        logic [15:0] pixel_c;
        logic [15:0] pixel_d;
        logic [15:0] pixel_e;
    } t_out_beat;

    // {bright, index} -> rgb565
    localparam logic [15:0] ColourTable [16] = '{
        16'h0000, 16'h0019, 16'hC800, 16'hC819, 16'h0660, 16'h0679, 16'hCE60, 16'hCE79,
        16'h0000, 16'h001F, 16'hF800, 16'hF81F, 16'h07E0, 16'h07FF, 16'hFFE0, 16'hFFFF
    };

    function automatic logic [15:0] palette(input logic [2:0] index, input logic bright);
        return ColourTable[{bright, index}];
    endfunction

endpackage

[rtl/core/screen_line_renderer.sv]
// Screen memory with pixel-group renderer. An accepted render beat passes the memory read
// register, then the colour register, into its output beat; write beats give none.
// Throughput: one item per cycle unless the output stalls, set by the single read port of each memory
// (bitmap and attribute are read in the same cycle). Backpressure stalls input
// only when both internal stages are full and the output stalls. Reset: synchronous, clears valid flags
// and the border colour; screen memory is not cleared and holds garbage until written.
`include "assert_macros.svh"

module screen_line_renderer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  slr_pkg::t_in_beat i_in_beat,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output slr_pkg::t_out_beat o_out_beat,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_data
);

    logic [7:0] r_bitmap_mem [slr_pkg::BitmapBytes];
    logic [7:0] r_attr_mem   [slr_pkg::AttrBytes];

    logic [2:0] r_border_color;
    logic       r_s1_valid;
    logic       r_s1_border;
    logic [7:0] r_bmp_q;
    logic [7:0] r_attr_q;
    logic       r_out_valid;
    slr_pkg::t_out_beat r_out_beat;
    slr_pkg::t_out_beat n_out_beat;

    logic        out_free;
    logic        advance;
    logic        in_accept;
    logic        rd_en;
    logic        wr_bitmap;
    logic        wr_attr;
    logic [6:0]  rel_line;
    logic [14:0] sy_prod;
    logic [7:0]  sy;
    logic        is_border;
    logic [slr_pkg::BitmapAw-1:0] bmp_raddr;
    logic [slr_pkg::AttrAw-1:0]   attr_raddr;
    logic [slr_pkg::AttrAw-1:0]   attr_waddr;
    logic [15:0] ink;
    logic [15:0] paper;
    logic [15:0] border_rgb;

    assign o_cfg_ready = 1'b1;

    // stage 1 moves on when empty or when the output register frees up
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = !r_s1_valid || out_free;
    assign o_in_stall = !advance;
    assign in_accept  = i_in_valid && advance;

    assign wr_bitmap = in_accept && (i_in_beat.kind == slr_pkg::WriteKind)
                       && (i_in_beat.address < 13'(slr_pkg::BitmapBytes));
    assign wr_attr   = in_accept && (i_in_beat.kind == slr_pkg::WriteKind)
                       && (i_in_beat.address >= 13'(slr_pkg::BitmapBytes))
                       && (i_in_beat.address < 13'(slr_pkg::ScreenBytes));
    assign attr_waddr = slr_pkg::AttrAw'(i_in_beat.address - 13'(slr_pkg::BitmapBytes));

    // read data register only reloads when stage 1 advances, so a held beat keeps its bytes
    assign rd_en = advance;

    // source row = rel * 8 / 5
    assign rel_line  = i_in_beat.line - 7'(slr_pkg::TopBorderRows);
    assign sy_prod   = 15'(rel_line) * 15'(slr_pkg::RecipFive);
    assign sy        = sy_prod[14:7];
    assign is_border = ({1'b0, i_in_beat.line} < 8'(slr_pkg::TopBorderRows))
                       || ({1'b0, i_in_beat.line} >= 8'(slr_pkg::BottomStart));

    // interleaved bitmap layout: third, char row bits, pixel row bits swapped
    assign bmp_raddr  = {sy[7:6], sy[2:0], sy[5:3], i_in_beat.group};
    assign attr_raddr = {sy[7:3], i_in_beat.group};

    always_ff @(posedge i_clk) begin
        if (wr_bitmap) begin
            r_bitmap_mem[i_in_beat.address] <= i_in_beat.data;
        end
        if (rd_en) begin
            r_bmp_q <= r_bitmap_mem[bmp_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_attr) begin
            r_attr_mem[attr_waddr] <= i_in_beat.data;
        end
        if (rd_en) begin
            r_attr_q <= r_attr_mem[attr_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_border_color <= 3'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_border_color <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= i_in_valid && (i_in_beat.kind == slr_pkg::RenderKind);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_border <= is_border;
        end
    end

    assign ink        = slr_pkg::palette(r_attr_q[2:0], r_attr_q[6]);
    assign paper      = slr_pkg::palette(r_attr_q[5:3], r_attr_q[6]);
    assign border_rgb = slr_pkg::palette(r_border_color, 1'b0);

    always_comb begin
        if (r_s1_border) begin
            n_out_beat.pixel_a = border_rgb;
            n_out_beat.pixel_b = border_rgb;
            n_out_beat.pixel_c = border_rgb;
            n_out_beat.pixel_d = border_rgb;
            n_out_beat.pixel_e = border_rgb;
        end else begin
            n_out_beat.pixel_a = r_bmp_q[7] ? ink : paper;
            n_out_beat.pixel_b = r_bmp_q[6] ? ink : paper;
            n_out_beat.pixel_c = r_bmp_q[4] ? ink : paper;
            n_out_beat.pixel_d = r_bmp_q[3] ? ink : paper;
            n_out_beat.pixel_e = r_bmp_q[1] ? ink : paper;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_beat <= n_out_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // input only stalls when both stages are full and the output is blocked
    `ASSERT_SAME(a_stall_only_when_full, o_in_stall, r_s1_valid && r_out_valid && i_out_stall)
    // an accepted render always lands in stage 1
    `ASSERT_NEXT(a_render_enters, in_accept && (i_in_beat.kind == slr_pkg::RenderKind), r_s1_valid)
    // a held stage 1 beat keeps its memory data
    `ASSERT_NEXT(a_read_held, r_s1_valid && !advance,
                 r_s1_valid && $stable(r_bmp_q) && $stable(r_attr_q))

endmodule
